@@ rtl/core/vsrt_pkg.sv @@
// Vertex set transform: shared types, constants and helper functions.
// Trig table, cube reset corners, angle reduction and saturation.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package vsrt_pkg;

  localparam int unsigned VERTEX_COUNT    = 8;
  localparam int unsigned IDX_W           = $clog2(VERTEX_COUNT);
  localparam int unsigned CNT_W           = IDX_W + 1;
  localparam int unsigned OUT_IDX_W       = 3;
  localparam int unsigned COORD_W         = 32;
  localparam int unsigned COORD_FRAC_BITS = 16;
  localparam int unsigned SUM_W           = COORD_W + IDX_W;
  localparam int unsigned DIFF_W          = COORD_W + 1;
  localparam int unsigned COEF_W          = 18;
  localparam int unsigned PROD_W          = DIFF_W + COEF_W;
  localparam int unsigned ACC_W           = PROD_W + 5;
  localparam int unsigned TRIG_SHIFT      = 15;
  localparam int unsigned SCALE_SHIFT     = 12;
  localparam int unsigned CUBE_HALF       = 20;

  localparam logic [IDX_W-1:0]     IDX_LAST     = IDX_W'(VERTEX_COUNT - 1);
  localparam logic [CNT_W-1:0]     CNT_END      = CNT_W'(VERTEX_COUNT);
  localparam logic [OUT_IDX_W-1:0] OUT_IDX_LAST = OUT_IDX_W'(VERTEX_COUNT - 1);
  localparam logic [1:0]           STEP_LAST    = 2'd3;

  localparam logic signed [ACC_W-1:0] ROUND_TRIG  = ACC_W'(1) << (TRIG_SHIFT - 1);
  localparam logic signed [ACC_W-1:0] ROUND_SCALE = ACC_W'(1) << (SCALE_SHIFT - 1);
  localparam logic signed [COORD_W-1:0] CUBE_H =
      COORD_W'(CUBE_HALF * (2 ** COORD_FRAC_BITS));

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  typedef enum logic [2:0] {
    KIND_ROT_X = 3'd0,
    KIND_ROT_Y = 3'd1,
    KIND_ROT_Z = 3'd2,
    KIND_SCALE = 3'd3,
    KIND_MOVE  = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_CENT,
    ST_READ,
    ST_DIFF,
    ST_MUL,
    ST_DRAIN,
    ST_WB
  } state_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vertex_t;

  typedef struct packed {
    logic             cmd_ld;
    logic             re;
    logic [IDX_W-1:0] raddr;
    logic             sum_en;
    logic             cent_ld;
    logic             diff_ld;
    logic             mul_en;
    logic [1:0]       step;
    logic             wb;
    logic             last;
    logic [IDX_W-1:0] idx;
  } ctrl_t;

  // sine, first quadrant, Q1.15
  localparam logic [15:0] SIN_Q15 [91] = '{
        0,   572,  1144,  1715,  2286,  2856,  3425,  3993,  4560,  5126,
     5690,  6252,  6813,  7371,  7927,  8481,  9032,  9580, 10126, 10668,
    11207, 11743, 12275, 12803, 13328, 13848, 14365, 14876, 15384, 15886,
    16384, 16877, 17364, 17847, 18324, 18795, 19261, 19720, 20174, 20622,
    21063, 21498, 21926, 22348, 22763, 23170, 23571, 23965, 24351, 24730,
    25102, 25466, 25822, 26170, 26510, 26842, 27166, 27482, 27789, 28088,
    28378, 28660, 28932, 29197, 29452, 29698, 29935, 30163, 30382, 30592,
    30792, 30983, 31164, 31336, 31499, 31651, 31795, 31928, 32052, 32166,
    32270, 32365, 32449, 32524, 32588, 32643, 32688, 32723, 32748, 32763,
    32768
  };

  function automatic logic [8:0] reduce_deg(input logic signed [9:0] d);
    logic [10:0] v;
    v = 11'($signed({d[9], d}) + 11'sd720);
    if (v >= 11'd1080) begin
      v = v - 11'd1080;
    end else if (v >= 11'd720) begin
      v = v - 11'd720;
    end else if (v >= 11'd360) begin
      v = v - 11'd360;
    end
    return v[8:0];
  endfunction

  function automatic logic signed [COEF_W-1:0] sin_deg(input logic [8:0] a);
    logic [6:0]  idx;
    logic        neg;
    logic [15:0] mag;
    if (a <= 9'd90) begin
      idx = a[6:0];
      neg = 1'b0;
    end else if (a <= 9'd180) begin
      idx = 7'(9'd180 - a);
      neg = 1'b0;
    end else if (a <= 9'd270) begin
      idx = 7'(a - 9'd180);
      neg = 1'b1;
    end else begin
      idx = 7'(9'd360 - a);
      neg = 1'b1;
    end
    mag = SIN_Q15[idx];
    return neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
  endfunction

  function automatic logic signed [COEF_W-1:0] cos_deg(input logic [8:0] a);
    logic [9:0] b;
    b = {1'b0, a} + 10'd90;
    if (b >= 10'd360) begin
      b = b - 10'd360;
    end
    return sin_deg(b[8:0]);
  endfunction

  function automatic vertex_t cube_corner(input logic [IDX_W-1:0] i);
    logic [2:0] k;
    vertex_t    v;
    k   = 3'(i);
    v.x = (k == 3'd1 || k == 3'd2 || k == 3'd5 || k == 3'd6) ? CUBE_H : -CUBE_H;
    v.y = k[1] ? CUBE_H : -CUBE_H;
    v.z = k[2] ? -CUBE_H : CUBE_H;
    return v;
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_coord(
      input logic signed [ACC_W-1:0] v);
    if ((&v[ACC_W-1:COORD_W-1]) || !(|v[ACC_W-1:COORD_W-1])) begin
      return v[COORD_W-1:0];
    end else if (v[ACC_W-1]) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/vsrt_store.sv @@
// Vertex store: one synchronous memory of x/y/z entries, one read and one write port.
// Per-entry written bits stand in for the cube reset; uses vsrt_pkg.
`default_nettype none

module vsrt_store (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       re_i,
  input  logic [vsrt_pkg::IDX_W-1:0] raddr_i,
  output vsrt_pkg::vertex_t          rdata_o,
  input  logic                       we_i,
  input  logic [vsrt_pkg::IDX_W-1:0] waddr_i,
  input  vsrt_pkg::vertex_t          wdata_i
);

  vsrt_pkg::vertex_t                mem_q [vsrt_pkg::VERTEX_COUNT];
  logic [vsrt_pkg::VERTEX_COUNT-1:0] written_q;
  vsrt_pkg::vertex_t                rd_q;
  logic                             rd_vld_q;
  logic [vsrt_pkg::IDX_W-1:0]       rd_addr_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q      <= mem_q[raddr_i];
      rd_addr_q <= raddr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (we_i) begin
        written_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rd_vld_q <= written_q[raddr_i];
      end
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : vsrt_pkg::cube_corner(rd_addr_q);

endmodule

`default_nettype wire

@@ rtl/core/vsrt_ctrl.sv @@
// Sequencer: centroid pass, then read / difference / four multiply steps / drain / write-back
// per vertex. Drives the datapath and store through vsrt_pkg::ctrl_t.
`default_nettype none

module vsrt_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  output vsrt_pkg::ctrl_t ctrl_o
);

  vsrt_pkg::state_e                state_q, state_d;
  logic [vsrt_pkg::CNT_W-1:0]      cnt_q;
  logic [vsrt_pkg::IDX_W-1:0]      vidx_q;
  logic [1:0]                      step_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vsrt_pkg::ST_IDLE: begin
        if (start_i) state_d = vsrt_pkg::ST_SUM;
      end
      vsrt_pkg::ST_SUM: begin
        if (cnt_q == vsrt_pkg::CNT_END) state_d = vsrt_pkg::ST_CENT;
      end
      vsrt_pkg::ST_CENT:  state_d = vsrt_pkg::ST_READ;
      vsrt_pkg::ST_READ:  state_d = vsrt_pkg::ST_DIFF;
      vsrt_pkg::ST_DIFF:  state_d = vsrt_pkg::ST_MUL;
      vsrt_pkg::ST_MUL: begin
        if (step_q == vsrt_pkg::STEP_LAST) state_d = vsrt_pkg::ST_DRAIN;
      end
      vsrt_pkg::ST_DRAIN: state_d = vsrt_pkg::ST_WB;
      vsrt_pkg::ST_WB: begin
        state_d = (vidx_q == vsrt_pkg::IDX_LAST) ? vsrt_pkg::ST_IDLE : vsrt_pkg::ST_READ;
      end
      default:            state_d = vsrt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vsrt_pkg::ST_IDLE;
      cnt_q   <= '0;
      vidx_q  <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        vsrt_pkg::ST_IDLE: begin
          cnt_q  <= '0;
          vidx_q <= '0;
          step_q <= '0;
        end
        vsrt_pkg::ST_SUM: cnt_q  <= cnt_q + 1'b1;
        vsrt_pkg::ST_MUL: step_q <= step_q + 1'b1;
        vsrt_pkg::ST_WB:  vidx_q <= vidx_q + 1'b1;
        default: ;
      endcase
    end
  end

  always_comb begin
    ctrl_o         = '0;
    ctrl_o.cmd_ld  = (state_q == vsrt_pkg::ST_IDLE) && start_i;
    ctrl_o.re      = ((state_q == vsrt_pkg::ST_SUM) && (cnt_q != vsrt_pkg::CNT_END))
                     || (state_q == vsrt_pkg::ST_READ);
    ctrl_o.raddr   = (state_q == vsrt_pkg::ST_SUM) ? cnt_q[vsrt_pkg::IDX_W-1:0] : vidx_q;
    ctrl_o.sum_en  = (state_q == vsrt_pkg::ST_SUM) && (cnt_q != '0);
    ctrl_o.cent_ld = (state_q == vsrt_pkg::ST_CENT);
    ctrl_o.diff_ld = (state_q == vsrt_pkg::ST_DIFF);
    ctrl_o.mul_en  = (state_q == vsrt_pkg::ST_MUL);
    ctrl_o.step    = step_q;
    ctrl_o.wb      = (state_q == vsrt_pkg::ST_WB);
    ctrl_o.last    = (vidx_q == vsrt_pkg::IDX_LAST);
    ctrl_o.idx     = vidx_q;
    busy_o         = (state_q != vsrt_pkg::ST_IDLE);
  end

endmodule

`default_nettype wire

@@ rtl/core/vsrt_datapath.sv @@
// Datapath: command registers, centroid sums, one shared multiplier with three
// accumulators, write-back saturation and the result register. Uses vsrt_pkg.
`default_nettype none

module vsrt_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  vsrt_pkg::ctrl_t                    ctrl_i,
  input  logic [2:0]                         kind_i,
  input  logic signed [9:0]                  angle_deg_i,
  input  logic [15:0]                        scale_factor_i,
  input  logic signed [15:0]                 offset_x_i,
  input  logic signed [15:0]                 offset_y_i,
  input  logic signed [15:0]                 offset_z_i,
  input  vsrt_pkg::vertex_t                  rdata_i,
  output vsrt_pkg::vertex_t                  wdata_o,
  output logic                               result_strobe_o,
  output logic [2:0]                         vertex_index_o,
  output logic signed [31:0]                 coord_x_o,
  output logic signed [31:0]                 coord_y_o,
  output logic signed [31:0]                 coord_z_o,
  output logic                               last_o
);

  localparam int unsigned COORD_W   = vsrt_pkg::COORD_W;
  localparam int unsigned SUM_W     = vsrt_pkg::SUM_W;
  localparam int unsigned DIFF_W    = vsrt_pkg::DIFF_W;
  localparam int unsigned COEF_W    = vsrt_pkg::COEF_W;
  localparam int unsigned PROD_W    = vsrt_pkg::PROD_W;
  localparam int unsigned ACC_W     = vsrt_pkg::ACC_W;
  localparam int unsigned OUT_IDX_W = vsrt_pkg::OUT_IDX_W;

  logic [2:0]                 kind_q;
  logic [8:0]                 ang_q;
  logic [15:0]                sf_q;
  logic signed [15:0]         off_q  [3];
  logic signed [SUM_W-1:0]    sum_q  [3];
  logic signed [COORD_W-1:0]  cent_q [3];
  logic signed [COEF_W-1:0]   sin_q, cos_q;
  logic signed [COORD_W-1:0]  rd     [3];
  logic signed [COORD_W-1:0]  v_q    [3];
  logic signed [DIFF_W-1:0]   d_q    [3];
  logic signed [ACC_W-1:0]    acc_q  [3];
  logic signed [COORD_W-1:0]  new_c  [3];

  logic signed [DIFF_W-1:0]   op;
  logic signed [COEF_W-1:0]   coef;
  logic [1:0]                 tgt;
  logic                       hit;
  logic signed [PROD_W-1:0]   prod_q;
  logic                       prod_en_q;
  logic [1:0]                 prod_tgt_q;

  logic                       is_rot, is_scale, is_move;
  logic [1:0]                 ax_a, ax_b, ax_p, ax_q;
  logic [2:0]                 touched;

  function automatic logic signed [DIFF_W-1:0] pick3(
      input logic signed [DIFF_W-1:0] a0,
      input logic signed [DIFF_W-1:0] a1,
      input logic signed [DIFF_W-1:0] a2,
      input logic [1:0]               ax);
    logic signed [DIFF_W-1:0] r;
    if (ax == vsrt_pkg::AX_Y) begin
      r = a1;
    end else if (ax == vsrt_pkg::AX_Z) begin
      r = a2;
    end else begin
      r = a0;
    end
    return r;
  endfunction

  assign rd[0] = rdata_i.x;
  assign rd[1] = rdata_i.y;
  assign rd[2] = rdata_i.z;

  always_comb begin
    is_rot   = (kind_q == vsrt_pkg::KIND_ROT_X) || (kind_q == vsrt_pkg::KIND_ROT_Y)
               || (kind_q == vsrt_pkg::KIND_ROT_Z);
    is_scale = (kind_q == vsrt_pkg::KIND_SCALE);
    is_move  = (kind_q == vsrt_pkg::KIND_MOVE);
    // a, b: source axes; p, q: axes written by the first and second sum of products
    if (kind_q == vsrt_pkg::KIND_ROT_X) begin
      ax_a = vsrt_pkg::AX_Y; ax_b = vsrt_pkg::AX_Z;
      ax_p = vsrt_pkg::AX_Y; ax_q = vsrt_pkg::AX_Z;
    end else if (kind_q == vsrt_pkg::KIND_ROT_Y) begin
      ax_a = vsrt_pkg::AX_Z; ax_b = vsrt_pkg::AX_X;
      ax_p = vsrt_pkg::AX_Z; ax_q = vsrt_pkg::AX_X;
    end else begin
      ax_a = vsrt_pkg::AX_X; ax_b = vsrt_pkg::AX_Y;
      ax_p = vsrt_pkg::AX_X; ax_q = vsrt_pkg::AX_Y;
    end
  end

  // steps: a*cos, -b*sin into p; a*sin, b*cos into q. Scale uses steps 0..2 per axis.
  always_comb begin
    op   = '0;
    coef = '0;
    tgt  = vsrt_pkg::AX_X;
    hit  = 1'b0;
    if (is_rot) begin
      op   = ctrl_i.step[0] ? pick3(d_q[0], d_q[1], d_q[2], ax_b)
                            : pick3(d_q[0], d_q[1], d_q[2], ax_a);
      coef = (ctrl_i.step[0] == ctrl_i.step[1]) ? cos_q
                                                : (ctrl_i.step[0] ? -sin_q : sin_q);
      tgt  = ctrl_i.step[1] ? ax_q : ax_p;
      hit  = 1'b1;
    end else if (is_scale) begin
      op   = pick3(d_q[0], d_q[1], d_q[2], ctrl_i.step);
      coef = COEF_W'(sf_q);
      tgt  = ctrl_i.step;
      hit  = (ctrl_i.step != vsrt_pkg::STEP_LAST);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cmd_ld) begin
      kind_q   <= kind_i;
      ang_q    <= vsrt_pkg::reduce_deg(angle_deg_i);
      sf_q     <= scale_factor_i;
      off_q[0] <= offset_x_i;
      off_q[1] <= offset_y_i;
      off_q[2] <= offset_z_i;
    end
    if (ctrl_i.cent_ld) begin
      sin_q <= vsrt_pkg::sin_deg(ang_q);
      cos_q <= vsrt_pkg::cos_deg(ang_q);
    end
    prod_q     <= op * coef;
    prod_tgt_q <= tgt;
    for (int i = 0; i < 3; i++) begin
      if (ctrl_i.cmd_ld) begin
        sum_q[i] <= '0;
      end else if (ctrl_i.sum_en) begin
        sum_q[i] <= sum_q[i] + SUM_W'(rd[i]);
      end
      if (ctrl_i.cent_ld) begin
        cent_q[i] <= COORD_W'(sum_q[i] >>> vsrt_pkg::IDX_W);
      end
      if (ctrl_i.diff_ld) begin
        v_q[i]   <= rd[i];
        d_q[i]   <= DIFF_W'(rd[i]) - DIFF_W'(cent_q[i]);
        // centroid and rounding half folded into the starting value
        acc_q[i] <= is_rot
            ? (ACC_W'(cent_q[i]) <<< vsrt_pkg::TRIG_SHIFT) + vsrt_pkg::ROUND_TRIG
            : (ACC_W'(cent_q[i]) <<< vsrt_pkg::SCALE_SHIFT) + vsrt_pkg::ROUND_SCALE;
      end else if (prod_en_q && (prod_tgt_q == 2'(i))) begin
        acc_q[i] <= acc_q[i] + ACC_W'(prod_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_en_q <= 1'b0;
    end else begin
      prod_en_q <= ctrl_i.mul_en && hit;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      touched[i] = is_scale || (is_rot && ((ax_p == 2'(i)) || (ax_q == 2'(i))));
      if (touched[i]) begin
        new_c[i] = vsrt_pkg::sat_coord(is_rot ? (acc_q[i] >>> vsrt_pkg::TRIG_SHIFT)
                                              : (acc_q[i] >>> vsrt_pkg::SCALE_SHIFT));
      end else if (is_move) begin
        new_c[i] = vsrt_pkg::sat_coord(ACC_W'(v_q[i])
                                       + (ACC_W'(off_q[i]) <<< vsrt_pkg::COORD_FRAC_BITS));
      end else begin
        new_c[i] = v_q[i];
      end
    end
  end

  assign wdata_o = {new_c[0], new_c[1], new_c[2]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_strobe_o <= 1'b0;
    end else begin
      result_strobe_o <= ctrl_i.wb;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wb) begin
      vertex_index_o <= OUT_IDX_W'(ctrl_i.idx);
      coord_x_o      <= new_c[0];
      coord_y_o      <= new_c[1];
      coord_z_o      <= new_c[2];
      last_o         <= ctrl_i.last;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/vertex_set_rigid_transform_top.sv @@
// Top level of the vertex set transform: sequencer, vertex store and datapath.
// Depends on vsrt_pkg, vsrt_ctrl, vsrt_store and vsrt_datapath.
//
//   channel   direction  handshake                  payload
//   command   in         start_i high, busy_o low  kind, angle_deg, scale_factor, offset_x/y/z
//   result    out        result_strobe_o, 1 cycle  vertex_index, coord_x/y/z, last
//
// A command keeps busy_o high through a centroid pass over the single memory read port,
// a step that loads the centroid and sine/cosine, then per vertex a read, a difference,
// the four products of the shared multiplier, a drain and a write-back.
// Results come one per vertex; the last shows in the same cycle that busy_o first reads low.
// Reset restores the cube; the receiver cannot stall, so nothing else holds a transaction.
// Read and write never hit the same entry in one cycle, so no forwarding is needed.
`default_nettype none

module vertex_set_rigid_transform_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [2:0]         kind_i,
  input  logic signed [9:0]  angle_deg_i,
  input  logic [15:0]        scale_factor_i,
  input  logic signed [15:0] offset_x_i,
  input  logic signed [15:0] offset_y_i,
  input  logic signed [15:0] offset_z_i,
  output logic               result_strobe_o,
  output logic [2:0]         vertex_index_o,
  output logic signed [31:0] coord_x_o,
  output logic signed [31:0] coord_y_o,
  output logic signed [31:0] coord_z_o,
  output logic               last_o
);

  vsrt_pkg::ctrl_t   ctrl;
  vsrt_pkg::vertex_t rdata;
  vsrt_pkg::vertex_t wdata;

  vsrt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .ctrl_o (ctrl)
  );

  vsrt_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .re_i   (ctrl.re),
    .raddr_i(ctrl.raddr),
    .rdata_o(rdata),
    .we_i   (ctrl.wb),
    .waddr_i(ctrl.idx),
    .wdata_i(wdata)
  );

  vsrt_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .kind_i         (kind_i),
    .angle_deg_i    (angle_deg_i),
    .scale_factor_i (scale_factor_i),
    .offset_x_i     (offset_x_i),
    .offset_y_i     (offset_y_i),
    .offset_z_i     (offset_z_i),
    .rdata_i        (rdata),
    .wdata_o        (wdata),
    .result_strobe_o(result_strobe_o),
    .vertex_index_o (vertex_index_o),
    .coord_x_o      (coord_x_o),
    .coord_y_o      (coord_y_o),
    .coord_z_o      (coord_z_o),
    .last_o         (last_o)
  );

endmodule

`default_nettype wire

@@ rtl/core/vsrt_checker.sv @@
// Port-level checks for the vertex set transform, bound to the top level.
// Depends on vsrt_pkg and vertex_set_rigid_transform_top.
`default_nettype none

module vsrt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       result_strobe_o,
  input logic [2:0] vertex_index_o,
  input logic       last_o
);

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted transaction did not raise busy");

  a_strobe_gap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |=> !result_strobe_o)
    else $error("results on consecutive cycles");

  a_mid_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && !last_o |-> busy_o)
    else $error("non-final result while idle");

  a_last_idx : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && last_o |-> vertex_index_o == vsrt_pkg::OUT_IDX_LAST)
    else $error("last flag on wrong vertex");

  a_start_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> !result_strobe_o)
    else $error("result overlaps start of a new transaction");

endmodule

bind vertex_set_rigid_transform_top vsrt_checker u_vsrt_checker (.*);

`default_nettype wire

@@ verif/vertex_set_rigid_transform_top_tb.sv @@
// Self-checking testbench for vertex_set_rigid_transform_top: directed commands, then random ones.
// Every command transaction updates an internal copy of the vertex set; emitted vertices are compared.
// Depends on vsrt_pkg (kind codes, fixed-point constants) and the top-level RTL only.
module vertex_set_rigid_transform_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] KIND_SPARE_A = 3'd5;
  localparam logic [2:0] KIND_SPARE_B = 3'd6;
  localparam logic [2:0] KIND_SPARE_C = 3'd7;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_CMDS  = 86;
  localparam int unsigned DRAIN_CYCLES = 16;

  // corner sign masks, bit i set where vertex i sits on the positive side
  localparam logic [7:0] CORNER_XP = 8'b0110_0110;
  localparam logic [7:0] CORNER_YP = 8'b1100_1100;
  localparam logic [7:0] CORNER_ZP = 8'b0000_1111;

  localparam int QUARTER_SINE [91] = '{
        0,   572,  1144,  1715,  2286,  2856,  3425,  3993,  4560,  5126,
     5690,  6252,  6813,  7371,  7927,  8481,  9032,  9580, 10126, 10668,
    11207, 11743, 12275, 12803, 13328, 13848, 14365, 14876, 15384, 15886,
    16384, 16877, 17364, 17847, 18324, 18795, 19261, 19720, 20174, 20622,
    21063, 21498, 21926, 22348, 22763, 23170, 23571, 23965, 24351, 24730,
    25102, 25466, 25822, 26170, 26510, 26842, 27166, 27482, 27789, 28088,
    28378, 28660, 28932, 29197, 29452, 29698, 29935, 30163, 30382, 30592,
    30792, 30983, 31164, 31336, 31499, 31651, 31795, 31928, 32052, 32166,
    32270, 32365, 32449, 32524, 32588, 32643, 32688, 32723, 32748, 32763,
    32768
  };

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [9:0]  angle;
    logic [15:0]        scale;
    logic signed [15:0] ox;
    logic signed [15:0] oy;
    logic signed [15:0] oz;
    logic [7:0]         cube_half;  // non-zero: result is the cube at this half size
  } command_t;

  typedef struct packed {
    logic [2:0]         idx;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               last;
  } vertex_out_t;

  localparam command_t DIRECTED [23] = '{
    '{KIND_SPARE_A, 10'sd0, 16'd0, 16'sd0, 16'sd0, 16'sd0, 8'd20},
    '{vsrt_pkg::KIND_ROT_X, 10'sd0, 16'd4096, 16'sd0, 16'sd0, 16'sd0, 8'd20},
    '{vsrt_pkg::KIND_ROT_Y, 10'sd360, 16'd4096, 16'sd0, 16'sd0, 16'sd0, 8'd20},
    '{vsrt_pkg::KIND_ROT_Z, -10'sd360, 16'd4096, 16'sd0, 16'sd0, 16'sd0, 8'd20},
    '{vsrt_pkg::KIND_SCALE, 10'sd0, 16'd4096, 16'sd0, 16'sd0, 16'sd0, 8'd20},
    '{vsrt_pkg::KIND_MOVE, 10'sd0, 16'd4096, 16'sd0, 16'sd0, 16'sd0, 8'd20},
    '{vsrt_pkg::KIND_SCALE, 10'sd0, 16'd8192, 16'sd0, 16'sd0, 16'sd0, 8'd40},
    '{vsrt_pkg::KIND_SCALE, 10'sd0, 16'd2048, 16'sd0, 16'sd0, 16'sd0, 8'd20},
    '{KIND_SPARE_B, 10'h1FF, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 8'd20},
    '{KIND_SPARE_C, 10'h200, 16'h0000, 16'h8000, 16'h8000, 16'h8000, 8'd20},
    '{vsrt_pkg::KIND_ROT_Z, 10'sd90, 16'd0, 16'sd0, 16'sd0, 16'sd0, 8'd0},
    '{vsrt_pkg::KIND_ROT_X, -10'sd90, 16'd0, 16'sd0, 16'sd0, 16'sd0, 8'd0},
    '{vsrt_pkg::KIND_ROT_Y, 10'sd45, 16'd0, 16'sd0, 16'sd0, 16'sd0, 8'd0},
    '{vsrt_pkg::KIND_ROT_Z, 10'h1FF, 16'd0, 16'sd0, 16'sd0, 16'sd0, 8'd0},
    '{vsrt_pkg::KIND_ROT_X, 10'h200, 16'd0, 16'sd0, 16'sd0, 16'sd0, 8'd0},
    '{vsrt_pkg::KIND_ROT_Y, 10'sd270, 16'd0, 16'sd0, 16'sd0, 16'sd0, 8'd0},
    '{vsrt_pkg::KIND_ROT_Z, 10'sd180, 16'd0, 16'sd0, 16'sd0, 16'sd0, 8'd0},
    '{vsrt_pkg::KIND_ROT_X, 10'sd1, 16'd0, 16'sd0, 16'sd0, 16'sd0, 8'd0},
    '{vsrt_pkg::KIND_MOVE, 10'sd90, 16'd0, 16'h7FFF, 16'h8000, 16'h7FFF, 8'd0},
    '{vsrt_pkg::KIND_MOVE, 10'sd90, 16'd0, 16'h8000, 16'h7FFF, 16'h8000, 8'd0},
    '{vsrt_pkg::KIND_SCALE, 10'sd0, 16'd256, 16'sd0, 16'sd0, 16'sd0, 8'd0},
    '{vsrt_pkg::KIND_SCALE, 10'sd0, 16'hFFFF, 16'sd0, 16'sd0, 16'sd0, 8'd0},
    '{vsrt_pkg::KIND_ROT_Y, -10'sd45, 16'd0, 16'sd0, 16'sd0, 16'sd0, 8'd0}
  };

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic [2:0]         kind_i;
  logic signed [9:0]  angle_deg_i;
  logic [15:0]        scale_factor_i;
  logic signed [15:0] offset_x_i;
  logic signed [15:0] offset_y_i;
  logic signed [15:0] offset_z_i;
  logic               result_strobe_o;
  logic [2:0]         vertex_index_o;
  logic signed [31:0] coord_x_o;
  logic signed [31:0] coord_y_o;
  logic signed [31:0] coord_z_o;
  logic               last_o;

  logic signed [31:0] vert_x [8];
  logic signed [31:0] vert_y [8];
  logic signed [31:0] vert_z [8];
  vertex_out_t        pending_vertices [$];

  int unsigned cycle_count;
  int unsigned mismatch_count;
  int unsigned vertices_checked;
  int unsigned rotate_cmds;
  int unsigned scale_cmds;
  int unsigned move_cmds;
  int unsigned spare_cmds;

  vertex_set_rigid_transform_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .kind_i          (kind_i),
    .angle_deg_i     (angle_deg_i),
    .scale_factor_i  (scale_factor_i),
    .offset_x_i      (offset_x_i),
    .offset_y_i      (offset_y_i),
    .offset_z_i      (offset_z_i),
    .result_strobe_o (result_strobe_o),
    .vertex_index_o  (vertex_index_o),
    .coord_x_o       (coord_x_o),
    .coord_y_o       (coord_y_o),
    .coord_z_o       (coord_z_o),
    .last_o          (last_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic longint clamp_coord(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint round_shift_right(input longint v, input int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint sine_of(input int a);
    if (a <= 90) return QUARTER_SINE[a];
    if (a <= 180) return QUARTER_SINE[180 - a];
    if (a <= 270) return -QUARTER_SINE[a - 180];
    return -QUARTER_SINE[360 - a];
  endfunction

  function automatic longint rotate_coord(input longint c, input longint a, input longint ca,
                                          input longint b, input longint cb);
    return clamp_coord(c + round_shift_right(a * ca + b * cb, vsrt_pkg::TRIG_SHIFT));
  endfunction

  task automatic advance_vertices(input command_t c);
    longint sum_x, sum_y, sum_z, cx, cy, cz;
    longint dx, dy, dz, nx, ny, nz, sn, cs, sf, unit_q;
    int a;
    sum_x = 0;
    sum_y = 0;
    sum_z = 0;
    for (int i = 0; i < 8; i++) begin
      sum_x += longint'(vert_x[i]);
      sum_y += longint'(vert_y[i]);
      sum_z += longint'(vert_z[i]);
    end
    cx = sum_x >>> 3;
    cy = sum_y >>> 3;
    cz = sum_z >>> 3;
    a = int'(c.angle) % 360;
    if (a < 0) a += 360;
    sn = sine_of(a);
    cs = sine_of((a + 90) % 360);
    sf = longint'(c.scale);
    unit_q = longint'(1) <<< vsrt_pkg::COORD_FRAC_BITS;
    for (int i = 0; i < 8; i++) begin
      nx = vert_x[i];
      ny = vert_y[i];
      nz = vert_z[i];
      dx = nx - cx;
      dy = ny - cy;
      dz = nz - cz;
      case (c.kind)
        vsrt_pkg::KIND_ROT_X: begin
          ny = rotate_coord(cy, dy, cs, dz, -sn);
          nz = rotate_coord(cz, dy, sn, dz, cs);
        end
        vsrt_pkg::KIND_ROT_Y: begin
          nx = rotate_coord(cx, dx, cs, dz, sn);
          nz = rotate_coord(cz, dz, cs, dx, -sn);
        end
        vsrt_pkg::KIND_ROT_Z: begin
          nx = rotate_coord(cx, dx, cs, dy, -sn);
          ny = rotate_coord(cy, dx, sn, dy, cs);
        end
        vsrt_pkg::KIND_SCALE: begin
          nx = clamp_coord(cx + round_shift_right(dx * sf, vsrt_pkg::SCALE_SHIFT));
          ny = clamp_coord(cy + round_shift_right(dy * sf, vsrt_pkg::SCALE_SHIFT));
          nz = clamp_coord(cz + round_shift_right(dz * sf, vsrt_pkg::SCALE_SHIFT));
        end
        vsrt_pkg::KIND_MOVE: begin
          nx = clamp_coord(nx + longint'(c.ox) * unit_q);
          ny = clamp_coord(ny + longint'(c.oy) * unit_q);
          nz = clamp_coord(nz + longint'(c.oz) * unit_q);
        end
        default: begin
        end
      endcase
      vert_x[i] = 32'(nx);
      vert_y[i] = 32'(ny);
      vert_z[i] = 32'(nz);
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  function automatic command_t random_command();
    command_t c;
    int r;
    c.angle     = 10'($urandom);
    c.scale     = 16'($urandom);
    c.ox        = 16'($urandom);
    c.oy        = 16'($urandom);
    c.oz        = 16'($urandom);
    c.cube_half = 8'd0;
    r = $urandom_range(0, 99);
    if (r < 54) begin
      c.kind = 3'($urandom_range(vsrt_pkg::KIND_ROT_X, vsrt_pkg::KIND_ROT_Z));
    end else if (r < 70) begin
      c.kind = vsrt_pkg::KIND_SCALE;
      if ($urandom_range(0, 9) != 0) c.scale = 16'($urandom_range(2048, 8192));
    end else if (r < 92) begin
      c.kind = vsrt_pkg::KIND_MOVE;
      c.ox   = 16'($urandom_range(0, 4000) - 2000);
      c.oy   = 16'($urandom_range(0, 4000) - 2000);
      c.oz   = 16'($urandom_range(0, 4000) - 2000);
    end else begin
      c.kind = 3'($urandom_range(KIND_SPARE_A, KIND_SPARE_C));
    end
    return c;
  endfunction

  task automatic issue_command(input command_t c, input int gap);
    vertex_out_t v;
    longint h;
    if (gap > 0) begin
      @(negedge clk_i) start_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    kind_i         <= c.kind;
    angle_deg_i    <= c.angle;
    scale_factor_i <= c.scale;
    offset_x_i     <= c.ox;
    offset_y_i     <= c.oy;
    offset_z_i     <= c.oz;
    start_i        <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (!busy_o) break;
    end
    advance_vertices(c);
    case (c.kind)
      vsrt_pkg::KIND_ROT_X, vsrt_pkg::KIND_ROT_Y, vsrt_pkg::KIND_ROT_Z: rotate_cmds++;
      vsrt_pkg::KIND_SCALE: scale_cmds++;
      vsrt_pkg::KIND_MOVE: move_cmds++;
      default: spare_cmds++;
    endcase
    h = longint'(c.cube_half) <<< vsrt_pkg::COORD_FRAC_BITS;
    for (int i = 0; i < 8; i++) begin
      v.idx  = 3'(i);
      v.last = (i == 7);
      if (c.cube_half != 8'd0) begin
        v.x = 32'(CORNER_XP[i] ? h : -h);
        v.y = 32'(CORNER_YP[i] ? h : -h);
        v.z = 32'(CORNER_ZP[i] ? h : -h);
      end else begin
        v.x = vert_x[i];
        v.y = vert_y[i];
        v.z = vert_z[i];
      end
      pending_vertices.push_back(v);
    end
  endtask

  function automatic void check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    vertex_out_t want;
    if (rst_ni && result_strobe_o) begin
      if (pending_vertices.size() == 0) begin
        $error("vertex %0d emitted with no command transaction pending", vertex_index_o);
        mismatch_count++;
      end else begin
        want = pending_vertices.pop_front();
        check_field("vertex_index", want.idx, vertex_index_o);
        check_field("coord_x", want.x, coord_x_o);
        check_field("coord_y", want.y, coord_y_o);
        check_field("coord_z", want.z, coord_z_o);
        check_field("last", want.last, last_o);
        vertices_checked++;
      end
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d vertices outstanding",
             cycle_count, pending_vertices.size());
    $display("vertex_set_rigid_transform_top: mismatch");
    $finish;
  end

  initial begin
    command_t last_cmd;
    bit       burst;
    cycle_count      = 0;
    mismatch_count   = 0;
    vertices_checked = 0;
    rotate_cmds      = 0;
    scale_cmds       = 0;
    move_cmds        = 0;
    spare_cmds       = 0;
    burst            = 1'b0;
    rst_ni           = 1'b0;
    start_i          = 1'b0;
    kind_i           = '0;
    angle_deg_i      = '0;
    scale_factor_i   = '0;
    offset_x_i       = '0;
    offset_y_i       = '0;
    offset_z_i       = '0;
    for (int i = 0; i < 8; i++) begin
      vert_x[i] = (CORNER_XP[i] ? 32'sd20 : -32'sd20) <<< vsrt_pkg::COORD_FRAC_BITS;
      vert_y[i] = (CORNER_YP[i] ? 32'sd20 : -32'sd20) <<< vsrt_pkg::COORD_FRAC_BITS;
      vert_z[i] = (CORNER_ZP[i] ? 32'sd20 : -32'sd20) <<< vsrt_pkg::COORD_FRAC_BITS;
    end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    for (int n = 0; n < $size(DIRECTED); n++) begin
      issue_command(DIRECTED[n], pick_gap());
    end
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      if (n % 10 == 0) burst = ($urandom_range(0, 2) == 0);
      issue_command(random_command(), burst ? 0 : pick_gap());
    end
    // zero scale collapses the set onto its centroid for good, so it goes last
    last_cmd           = '0;
    last_cmd.kind      = vsrt_pkg::KIND_SCALE;
    last_cmd.scale     = 16'd0;
    last_cmd.cube_half = 8'd0;
    issue_command(last_cmd, pick_gap());
    @(negedge clk_i) start_i <= 1'b0;

    while (pending_vertices.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("ran %0d rotate, %0d scale, %0d translate and %0d spare-kind commands",
             rotate_cmds, scale_cmds, move_cmds, spare_cmds);
    $display("compared %0d emitted vertices, %0d field errors", vertices_checked,
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("vertex_set_rigid_transform_top: match");
    end else begin
      $display("vertex_set_rigid_transform_top: mismatch");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/vsrt_pkg.sv
rtl/core/vsrt_store.sv
rtl/core/vsrt_ctrl.sv
rtl/core/vsrt_datapath.sv
rtl/core/vertex_set_rigid_transform_top.sv
rtl/core/vsrt_checker.sv
verif/vertex_set_rigid_transform_top_tb.sv
